// ===== rtl/core/mtfl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfl_pkg: shared types and constants for the move-to-front list
// Request and status codes, cell commands and the controller states.
// ----------------------------------------------------------------------------
package mtfl_pkg;

  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned PosW          = 6;
  localparam int unsigned ValW          = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what a cell loads on a commit cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_cmd_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

endpackage

// ===== rtl/core/mtfl_cell.sv =====
// ----------------------------------------------------------------------------
// mtfl_cell: one list slot
// Holds one entry, shifts from either neighbor or loads the request value,
// and registers an equality compare against the key for search.
// ----------------------------------------------------------------------------
module mtfl_cell
  import mtfl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_e        cmd_i,
  input  logic [ValW-1:0]  key_i,
  input  logic [ValW-1:0]  left_i,
  input  logic [ValW-1:0]  right_i,
  input  logic             cmp_en_i,
  output logic [ValW-1:0]  data_o,
  output logic             hit_o
);

  logic [ValW-1:0] data_q, data_d;
  logic            hit_q;

  always_comb begin
    case (cmd_i)
      CELL_LOAD:  data_d = key_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmp_en_i) begin
      hit_q <= (data_q == key_i);
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

// ===== rtl/core/move_to_front_positional_list.sv =====
// ----------------------------------------------------------------------------
// move_to_front_positional_list: bounded list with move-to-front search
// A row of cells holds the list in order; insert, get, remove and search
// requests each give one response with status, count and empty flag.
// ----------------------------------------------------------------------------
// A request runs through the idle and execute states: in the accept cycle every
// cell compares its entry with the request value, and in the execute state the
// controller picks the first hit and all cells shift or load at once while the
// response is registered. A new request is taken once the previous one has
// reached the output register, so requests do not overlap; a stalled response
// holds the execute state.
// Entries come up undefined after reset; only positions below the count are
// ever read. Positions are 6 bits, so only the first 63 slots are addressable.
module move_to_front_positional_list
  import mtfl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[5:0], value[37:6], zero pad
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // read_value[31:0], found_position[37:32],
                                     // entry_count[43:38], is_empty[44], zero pad
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned W  = ((CW > PosW) ? CW : PosW) + 1;

  fsm_e state_q, state_d;

  req_e             req_q;
  logic [PosW-1:0]  pos_q;
  logic [ValW-1:0]  val_q;
  logic [CW-1:0]    count_q, count_d;

  logic             m_valid_q;
  logic [47:0]      m_data_q;
  logic [1:0]       m_user_q;

  logic             accept;
  logic             out_free;
  logic             commit;

  logic [ValW-1:0]  cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_hit;
  logic [MAX_ENTRIES-1:0] hit_vec;
  cell_cmd_e        cell_cmd  [MAX_ENTRIES];

  logic [W-1:0]     pos_w, cnt_w, sel_w;
  logic [IW-1:0]    sel_idx;
  logic [IW-1:0]    hit_idx;
  logic             hit_any;
  logic             ins_ok, rem_ok, srch_ok;
  status_e          status;
  logic [ValW-1:0]  rd_val;
  logic [PosW-1:0]  found_pos;
  logic [W-1:0]     cnt_next_w;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid_q | m_axis_tready;
  assign commit   = (state_q == FSM_EXEC) & out_free;

  // controller
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(s_axis_tuser);
      pos_q <= s_axis_tdata[PosW-1:0];
      val_q <= s_axis_tdata[PosW+ValW-1:PosW];
    end
  end

  // request decode
  assign pos_w   = W'(pos_q);
  assign cnt_w   = W'(count_q);
  assign sel_w   = pos_w - W'(1);
  assign sel_idx = sel_w[IW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = cell_hit[i] & (W'(i) < cnt_w);
    end
  end

  // first hit wins
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IW'(i);
    end
  end
  assign hit_any = |hit_vec;

  always_comb begin
    status  = ST_OK;
    ins_ok  = 1'b0;
    rem_ok  = 1'b0;
    srch_ok = 1'b0;
    rd_val  = '0;
    unique case (req_q)
      REQ_INSERT: begin
        if (count_q == CW'(MAX_ENTRIES)) begin
          status = ST_FULL;
        end else if (pos_q == '0 || pos_w > cnt_w + W'(1)) begin
          status = ST_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      REQ_GET: begin
        if (pos_q == '0 || pos_w > cnt_w) begin
          status = ST_RANGE;
        end else begin
          rd_val = cell_data[sel_idx];
        end
      end
      REQ_REMOVE: begin
        if (pos_q == '0 || pos_w > cnt_w) begin
          status = ST_RANGE;
        end else begin
          rem_ok = 1'b1;
        end
      end
      REQ_SEARCH: begin
        srch_ok = hit_any;
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok)      count_d = count_q + CW'(1);
    else if (rem_ok) count_d = count_q - CW'(1);
  end

  assign cnt_next_w = W'(count_d);
  assign found_pos  = srch_ok ? PosW'(W'(hit_idx) + W'(1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= count_d;
    end
  end

  // cell row
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ValW-1:0] left_d, right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    always_comb begin
      cell_cmd[g] = CELL_HOLD;
      if (commit) begin
        if (ins_ok) begin
          if (W'(g) == sel_w)     cell_cmd[g] = CELL_LOAD;
          else if (W'(g) > sel_w) cell_cmd[g] = CELL_LEFT;
        end else if (rem_ok) begin
          if (W'(g) >= sel_w)     cell_cmd[g] = CELL_RIGHT;
        end else if (srch_ok) begin
          if (g == 0)                   cell_cmd[g] = CELL_LOAD;
          else if (IW'(g) <= hit_idx)   cell_cmd[g] = CELL_LEFT;
        end
      end
    end

    mtfl_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cell_cmd[g]),
      .key_i    (accept ? s_axis_tdata[PosW+ValW-1:PosW] : val_q),
      .left_i   (left_d),
      .right_i  (right_d),
      .cmp_en_i (accept),
      .data_o   (cell_data[g]),
      .hit_o    (cell_hit[g])
    );
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= {3'b000, (count_d == '0), cnt_next_w[PosW-1:0], found_pos, rd_val};
      m_user_q <= status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
